// File: rtl/hhc_pkg.sv
// ----------------------------------------------------------------------------
// hhc_pkg
// Types and constants shared by the humidifier hysteresis controller files.
// ----------------------------------------------------------------------------
package hhc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int TIME_W = 32;
    localparam int HUM_W  = 10;
    localparam int TANK_W = 12;
    localparam int MODE_W = 3;

    // Register indexes, byte address divided by four.
    localparam logic [2:0] REG_HUM_ON   = 3'd0;
    localparam logic [2:0] REG_HUM_OFF  = 3'd1;
    localparam logic [2:0] REG_TANK_LOW = 3'd2;
    localparam logic [2:0] REG_CONFIRM  = 3'd3;
    localparam logic [2:0] REG_MIN_ON   = 3'd4;
    localparam logic [2:0] REG_MIN_OFF  = 3'd5;

    localparam logic [HUM_W-1:0]  HUM_ON_RST   = 10'd600;
    localparam logic [HUM_W-1:0]  HUM_OFF_RST  = 10'd750;
    localparam logic [TANK_W-1:0] TANK_LOW_RST = 12'd200;
    localparam logic [TIME_W-1:0] CONFIRM_RST  = 32'd5000;
    localparam logic [TIME_W-1:0] MIN_ON_RST   = 32'd30000;
    localparam logic [TIME_W-1:0] MIN_OFF_RST  = 32'd60000;

    // Mode codes as seen on the result.
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAITING  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COOLDOWN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_WAITING  = 5'b00010,
        ST_RUNNING  = 5'b00100,
        ST_COOLDOWN = 5'b01000,
        ST_FAULT    = 5'b10000
    } state_t;

    typedef struct packed {
        logic [HUM_W-1:0]  humidity_on_level;
        logic [HUM_W-1:0]  humidity_off_level;
        logic [TANK_W-1:0] tank_low_level;
        logic [TIME_W-1:0] confirm_time_ms;
        logic [TIME_W-1:0] min_on_time_ms;
        logic [TIME_W-1:0] min_off_time_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [HUM_W-1:0]  humidity;
        logic              sensor_error;
        logic [TANK_W-1:0] tank_level;
    } item_t;

    typedef struct packed {
        logic              humidifier_on;
        logic [MODE_W-1:0] mode;
    } result_t;

endpackage

// File: rtl/hhc_regs.sv
// ----------------------------------------------------------------------------
// hhc_regs
// Configuration register bank behind the APB-style port.
// ----------------------------------------------------------------------------
module hhc_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hhc_pkg::ADDR_W-1:0] paddr,
    input  logic [hhc_pkg::DATA_W-1:0] pwdata,
    output logic [hhc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output hhc_pkg::cfg_t              cfg
);

    hhc_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.humidity_on_level  <= hhc_pkg::HUM_ON_RST;
            cfg_reg.humidity_off_level <= hhc_pkg::HUM_OFF_RST;
            cfg_reg.tank_low_level     <= hhc_pkg::TANK_LOW_RST;
            cfg_reg.confirm_time_ms    <= hhc_pkg::CONFIRM_RST;
            cfg_reg.min_on_time_ms     <= hhc_pkg::MIN_ON_RST;
            cfg_reg.min_off_time_ms    <= hhc_pkg::MIN_OFF_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                hhc_pkg::REG_HUM_ON:   cfg_reg.humidity_on_level  <= pwdata[hhc_pkg::HUM_W-1:0];
                hhc_pkg::REG_HUM_OFF:  cfg_reg.humidity_off_level <= pwdata[hhc_pkg::HUM_W-1:0];
                hhc_pkg::REG_TANK_LOW: cfg_reg.tank_low_level     <= pwdata[hhc_pkg::TANK_W-1:0];
                hhc_pkg::REG_CONFIRM:  cfg_reg.confirm_time_ms    <= pwdata;
                hhc_pkg::REG_MIN_ON:   cfg_reg.min_on_time_ms     <= pwdata;
                hhc_pkg::REG_MIN_OFF:  cfg_reg.min_off_time_ms    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            hhc_pkg::REG_HUM_ON:   prdata = {22'd0, cfg_reg.humidity_on_level};
            hhc_pkg::REG_HUM_OFF:  prdata = {22'd0, cfg_reg.humidity_off_level};
            hhc_pkg::REG_TANK_LOW: prdata = {20'd0, cfg_reg.tank_low_level};
            hhc_pkg::REG_CONFIRM:  prdata = cfg_reg.confirm_time_ms;
            hhc_pkg::REG_MIN_ON:   prdata = cfg_reg.min_on_time_ms;
            hhc_pkg::REG_MIN_OFF:  prdata = cfg_reg.min_off_time_ms;
            default:               prdata = '0;
        endcase
    end

endmodule

// File: rtl/hhc_fsm.sv
// ----------------------------------------------------------------------------
// hhc_fsm
// Controller state machine: evaluates one item per step and updates the
// mode, the timing marks and the relay level.
// ----------------------------------------------------------------------------
module hhc_fsm
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  hhc_pkg::item_t   item,
    input  hhc_pkg::cfg_t    cfg,
    output hhc_pkg::result_t result
);

    hhc_pkg::state_t                state_reg, state_next;
    logic [hhc_pkg::TIME_W-1:0]     phase_reg, phase_next;
    logic [hhc_pkg::TIME_W-1:0]     run_reg, run_next;
    logic                           relay_reg, relay_next;
    logic [hhc_pkg::TIME_W-1:0]     phase_elapsed;
    logic [hhc_pkg::TIME_W-1:0]     run_elapsed;
    logic                           tank_low;
    logic                           fault;

    assign tank_low      = item.tank_level <= cfg.tank_low_level;
    assign fault         = item.sensor_error || tank_low;
    // Wrapping differences; a backwards step in time reads as a long wait.
    assign phase_elapsed = item.now_ms - phase_reg;
    assign run_elapsed   = item.now_ms - run_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        run_next   = run_reg;
        relay_next = relay_reg;
        unique case (state_reg)
            hhc_pkg::ST_WAITING:
            begin
                if (fault)
                    state_next = hhc_pkg::ST_FAULT;
                else if (item.humidity > cfg.humidity_on_level)
                    state_next = hhc_pkg::ST_IDLE;
                else if (phase_elapsed >= cfg.confirm_time_ms)
                begin
                    relay_next = 1'b1;
                    run_next   = item.now_ms;
                    state_next = hhc_pkg::ST_RUNNING;
                end
            end
            hhc_pkg::ST_RUNNING:
            begin
                if (fault)
                begin
                    relay_next = 1'b0;
                    state_next = hhc_pkg::ST_FAULT;
                end
                else if (run_elapsed >= cfg.min_on_time_ms &&
                         item.humidity >= cfg.humidity_off_level)
                begin
                    relay_next = 1'b0;
                    phase_next = item.now_ms;
                    state_next = hhc_pkg::ST_COOLDOWN;
                end
            end
            hhc_pkg::ST_COOLDOWN:
            begin
                // Cooldown ignores faults; only the minimum off time ends it.
                if (phase_elapsed >= cfg.min_off_time_ms)
                    state_next = hhc_pkg::ST_IDLE;
            end
            hhc_pkg::ST_FAULT:
            begin
                relay_next = 1'b0;
                if (!fault)
                    state_next = hhc_pkg::ST_IDLE;
            end
            default:
            begin
                relay_next = 1'b0;
                state_next = hhc_pkg::ST_IDLE;
                if (!fault && item.humidity <= cfg.humidity_on_level)
                begin
                    phase_next = item.now_ms;
                    state_next = hhc_pkg::ST_WAITING;
                end
            end
        endcase
    end

    always_comb
    begin
        result.humidifier_on = relay_next;
        unique case (state_next)
            hhc_pkg::ST_WAITING:  result.mode = hhc_pkg::MODE_WAITING;
            hhc_pkg::ST_RUNNING:  result.mode = hhc_pkg::MODE_RUNNING;
            hhc_pkg::ST_COOLDOWN: result.mode = hhc_pkg::MODE_COOLDOWN;
            hhc_pkg::ST_FAULT:    result.mode = hhc_pkg::MODE_FAULT;
            default:              result.mode = hhc_pkg::MODE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hhc_pkg::ST_IDLE;
            phase_reg <= '0;
            run_reg   <= '0;
            relay_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            run_reg   <= run_next;
            relay_reg <= relay_next;
        end
    end

    // The relay is only ever driven while running.
    a_relay_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        relay_reg |-> state_reg == hhc_pkg::ST_RUNNING)
        else $error("relay on outside running");

    // Cooldown can only hold or return to idle.
    a_cooldown_exit: assert property (@(posedge clk) disable iff (!rst_n)
        step && state_reg == hhc_pkg::ST_COOLDOWN |=>
        state_reg == hhc_pkg::ST_COOLDOWN || state_reg == hhc_pkg::ST_IDLE)
        else $error("illegal exit from cooldown");

    // Running is only entered from waiting, with a fresh run start mark.
    a_run_entry: assert property (@(posedge clk) disable iff (!rst_n)
        step && state_reg != hhc_pkg::ST_RUNNING && state_next == hhc_pkg::ST_RUNNING |=>
        $past(state_reg) == hhc_pkg::ST_WAITING && run_reg == $past(item.now_ms))
        else $error("bad entry into running");

endmodule

// File: rtl/humidifier_hysteresis_controller_core.sv
// ----------------------------------------------------------------------------
// humidifier_hysteresis_controller_core
// An item is held in the input register until the result register is free; the state
// update then loads the result register with its result.
// Throughput: one item per cycle while the result port is not held back; the state machine updates in a single pass.
// Reset: asynchronous, active low; mode idle, relay off, configuration registers
// at their default values.
// ----------------------------------------------------------------------------
module humidifier_hysteresis_controller_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    // APB-style configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hhc_pkg::ADDR_W-1:0] paddr,
    input  logic [hhc_pkg::DATA_W-1:0] pwdata,
    output logic [hhc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // Input items
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [55:0]                s_axis_tdata,  // now_ms[31:0], humidity[41:32],
                                                      // tank_level[53:42], zero fill
    input  logic                       s_axis_tuser,  // sensor_error
    // Result items
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata   // humidifier_on[0], mode[3:1],
                                                      // zero fill
);

    hhc_pkg::cfg_t    cfg;
    hhc_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    hhc_pkg::result_t result;
    hhc_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             step;
    logic             in_accept;

    hhc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held item is evaluated once the result register is free.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.now_ms       <= s_axis_tdata[31:0];
            in_item_reg.humidity     <= s_axis_tdata[41:32];
            in_item_reg.tank_level   <= s_axis_tdata[53:42];
            in_item_reg.sensor_error <= s_axis_tuser;
        end
        if (step)
            out_reg <= result;
    end

    hhc_fsm u_fsm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.mode, out_reg.humidifier_on};

endmodule
